// ===== design/glt_pkg.sv =====
// ----------------------------------------------------------------------------
// glt_pkg
// shared types and constants for the greek to latin transliterator
// ----------------------------------------------------------------------------
package glt_pkg;

    localparam int BYTE_W      = 8;
    localparam int MAX_OUT     = 3;
    localparam int CNT_W       = $clog2(MAX_OUT + 1);
    localparam int MAP_LEN     = 25;

    // letter maps, first character in the top bits
    localparam logic [MAP_LEN*BYTE_W-1:0] LOWER_MAP = "avgdezh8iklmnqoprsstyfxyw";
    localparam logic [MAP_LEN*BYTE_W-1:0] UPPER_MAP = "AVGDEZH8IKLMNQOPR-STYFXYW";

    localparam logic [BYTE_W-1:0] ACUTE_MARK = 8'd39;
    localparam logic [BYTE_W-1:0] DIAER_MARK = 8'd34;

    localparam logic [BYTE_W-1:0] CODE_PI_UP = 8'd208;
    localparam logic [BYTE_W-1:0] CODE_PI_LO = 8'd240;
    localparam logic [BYTE_W-1:0] CODE_TAU_UP = 8'd212;
    localparam logic [BYTE_W-1:0] CODE_TAU_LO = 8'd244;
    localparam logic [BYTE_W-1:0] CODE_MU_UP = 8'd204;
    localparam logic [BYTE_W-1:0] CODE_MU_LO = 8'd236;
    localparam logic [BYTE_W-1:0] CODE_NU_UP = 8'd205;
    localparam logic [BYTE_W-1:0] CODE_NU_LO = 8'd237;

    localparam logic [BYTE_W-1:0] LOWER_FIRST = 8'd225;
    localparam logic [BYTE_W-1:0] UPPER_FIRST = 8'd193;

    typedef enum logic [2:0] {
        NAS_NONE  = 3'd0,
        NAS_MU_LO = 3'd1,
        NAS_MU_UP = 3'd2,
        NAS_NU_LO = 3'd3,
        NAS_NU_UP = 3'd4
    } glt_nasal_t;

    // up to three bytes, byte 0 goes out first
    typedef struct packed {
        logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]               count;
    } glt_result_t;

endpackage

// ===== design/glt_xlate.sv =====
// ----------------------------------------------------------------------------
// glt_xlate
// table lookup for one code byte plus the remembered mu / nu state
// ----------------------------------------------------------------------------
module glt_xlate
    import glt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [BYTE_W-1:0]   code,
    input  logic                advance,
    output glt_result_t         result
);

    glt_nasal_t nasal_reg;
    glt_nasal_t nasal_next;

    logic [BYTE_W-1:0] lo_idx;
    logic [BYTE_W-1:0] up_idx;
    logic [BYTE_W-1:0] lo_char;
    logic [BYTE_W-1:0] up_char;

    assign lo_idx  = code - LOWER_FIRST;
    assign up_idx  = code - UPPER_FIRST;
    assign lo_char = LOWER_MAP[(MAP_LEN - 1 - int'(lo_idx[4:0])) * BYTE_W +: BYTE_W];
    assign up_char = UPPER_MAP[(MAP_LEN - 1 - int'(up_idx[4:0])) * BYTE_W +: BYTE_W];

    always_comb begin
        result.bytes = '0;
        result.count = CNT_W'(1);
        nasal_next   = NAS_NONE;
        if ((nasal_reg == NAS_MU_LO || nasal_reg == NAS_MU_UP)
            && (code == CODE_PI_UP || code == CODE_PI_LO)) begin
            result.bytes[0] = (nasal_reg == NAS_MU_LO) ? "b" : "B";
        end else if ((nasal_reg == NAS_NU_LO || nasal_reg == NAS_NU_UP)
                     && (code == CODE_TAU_UP || code == CODE_TAU_LO)) begin
            result.bytes[0] = (nasal_reg == NAS_NU_LO) ? "d" : "D";
        end else begin
            result.count = CNT_W'(2);
            case (code)
                8'd0: begin
                    result.count = '0;
                end
                8'd220: begin result.bytes[0] = "a"; result.bytes[1] = ACUTE_MARK; end
                8'd221: begin result.bytes[0] = "e"; result.bytes[1] = ACUTE_MARK; end
                8'd222: begin result.bytes[0] = "h"; result.bytes[1] = ACUTE_MARK; end
                8'd223: begin result.bytes[0] = "i"; result.bytes[1] = ACUTE_MARK; end
                8'd252: begin result.bytes[0] = "o"; result.bytes[1] = ACUTE_MARK; end
                8'd253: begin result.bytes[0] = "y"; result.bytes[1] = ACUTE_MARK; end
                8'd254: begin result.bytes[0] = "w"; result.bytes[1] = ACUTE_MARK; end
                8'd182: begin result.bytes[0] = ACUTE_MARK; result.bytes[1] = "A"; end
                8'd184: begin result.bytes[0] = ACUTE_MARK; result.bytes[1] = "E"; end
                8'd185: begin result.bytes[0] = ACUTE_MARK; result.bytes[1] = "H"; end
                8'd186: begin result.bytes[0] = ACUTE_MARK; result.bytes[1] = "I"; end
                8'd188: begin result.bytes[0] = ACUTE_MARK; result.bytes[1] = "O"; end
                8'd190: begin result.bytes[0] = ACUTE_MARK; result.bytes[1] = "Y"; end
                8'd191: begin result.bytes[0] = ACUTE_MARK; result.bytes[1] = "W"; end
                8'd218: begin result.bytes[0] = "I"; result.bytes[1] = DIAER_MARK; end
                8'd219: begin result.bytes[0] = "Y"; result.bytes[1] = DIAER_MARK; end
                8'd250: begin result.bytes[0] = "i"; result.bytes[1] = DIAER_MARK; end
                8'd251: begin result.bytes[0] = "u"; result.bytes[1] = DIAER_MARK; end
                8'd192: begin
                    result.bytes[0] = "i";
                    result.bytes[1] = ACUTE_MARK;
                    result.bytes[2] = DIAER_MARK;
                    result.count    = CNT_W'(3);
                end
                8'd224: begin
                    result.bytes[0] = "u";
                    result.bytes[1] = ACUTE_MARK;
                    result.bytes[2] = DIAER_MARK;
                    result.count    = CNT_W'(3);
                end
                8'd238: begin result.bytes[0] = "k"; result.bytes[1] = "s"; end
                8'd248: begin result.bytes[0] = "p"; result.bytes[1] = "s"; end
                8'd206: begin result.bytes[0] = "K"; result.bytes[1] = "S"; end
                8'd216: begin result.bytes[0] = "P"; result.bytes[1] = "S"; end
                default: begin
                    result.count = CNT_W'(1);
                    if (code inside {[8'd225:8'd249]}) begin
                        result.bytes[0] = lo_char;
                    end else if (code inside {[8'd193:8'd217]}) begin
                        result.bytes[0] = up_char;
                    end else begin
                        result.bytes[0] = code;
                    end
                end
            endcase
            case (code)
                CODE_MU_LO: nasal_next = NAS_MU_LO;
                CODE_MU_UP: nasal_next = NAS_MU_UP;
                CODE_NU_LO: nasal_next = NAS_NU_LO;
                CODE_NU_UP: nasal_next = NAS_NU_UP;
                default:    nasal_next = NAS_NONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nasal_reg <= NAS_NONE;
        end else if (advance) begin
            nasal_reg <= nasal_next;
        end
    end

endmodule

// ===== design/glt_outbuf.sv =====
// ----------------------------------------------------------------------------
// glt_outbuf
// result register that hands out one byte per word and shifts the rest down
// ----------------------------------------------------------------------------
module glt_outbuf
    import glt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  glt_result_t         load_data,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [BYTE_W-1:0]   m_tdata,
    output logic                m_tlast
);

    logic                           valid_reg;
    logic [MAX_OUT-1:0][BYTE_W-1:0] bytes_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           take;

    assign m_tvalid = valid_reg;
    assign m_tdata  = bytes_reg[0];
    assign m_tlast  = (cnt_reg == CNT_W'(1));
    assign take     = valid_reg && m_tready;
    assign free     = !valid_reg || (take && m_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (load) begin
            valid_reg <= (load_data.count != '0);
            cnt_reg   <= load_data.count;
        end else if (take) begin
            valid_reg <= !m_tlast;
            cnt_reg   <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= load_data.bytes;
        end else if (take) begin
            bytes_reg <= {{BYTE_W{1'b0}}, bytes_reg[MAX_OUT-1:1]};
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (cnt_reg != '0 && cnt_reg <= CNT_W'(MAX_OUT)))
        else $error("output count out of range while valid");

    a_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !m_tlast |=> valid_reg && cnt_reg == $past(cnt_reg) - CNT_W'(1))
        else $error("non-final word did not leave the rest pending");

    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        load && load_data.count != '0 |=> valid_reg && cnt_reg == $past(load_data.count))
        else $error("loaded result not presented");

endmodule

// ===== design/greek_latin_transliterator_core.sv =====
// ----------------------------------------------------------------------------
// greek_latin_transliterator_core
// iso-8859-7 to latin transliteration, one code byte in, zero to three out
// ----------------------------------------------------------------------------
// Each accepted code byte is held in an input register, translated by a
// single table lookup and moved into a result register that hands out its
// bytes one word per cycle while m_tready is high, tlast marking the final
// byte of that input. Each code byte produces one to three output bytes on
// the single byte-wide result channel; a zero byte produces nothing. The
// input register takes the next code byte while the result register drains,
// and that byte moves on as the final word is taken. Pi after mu and tau
// after nu become b and d, cased after the mu or nu.
// ----------------------------------------------------------------------------
module greek_latin_transliterator_core
    import glt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,    // [7:0] code_byte
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [BYTE_W-1:0]   m_tdata,    // [7:0] out_byte
    output logic                m_tlast     // run_end
);

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_code_reg;

    logic        res_free;
    logic        advance;
    glt_result_t xl_result;

    // item moves on once the result register is empty or emptying
    assign advance  = in_valid_reg && res_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_code_reg <= s_tdata;
        end
    end

    // lookup and mu / nu memory, state steps only when the item moves on
    glt_xlate u_xlate (
        .aclk    (aclk),
        .aresetn (aresetn),
        .code    (in_code_reg),
        .advance (advance),
        .result  (xl_result)
    );

    // result register and byte serializer
    glt_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .load_data (xl_result),
        .free      (res_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for greek_latin_transliterator_core
// ----------------------------------------------------------------------------
// Code bytes go in on the s_ stream. A shadow copy of the mu/nu memory and the
// letter tables works out the latin words that each accepted code byte must
// produce. Those words are queued, and every word taken off the m_ stream is
// compared with the head of the queue, data and tlast both. A directed
// sequence covers table corners and the mu-pi / nu-tau rules. Random sequences
// follow, built mostly around mu and nu. Both sides idle at random. One phase
// holds the result side off long enough to back up the input side. The last
// phase runs without any idling.
// ----------------------------------------------------------------------------
module tb_top;
    import glt_pkg::*;

    // latin letters for the lowercase and uppercase greek runs, first in the top bits
    localparam logic [25*8-1:0] LATIN_LO = "avgdezh8iklmnqoprsstyfxyw";
    localparam logic [25*8-1:0] LATIN_UP = "AVGDEZH8IKLMNQOPR-STYFXYW";

    typedef struct {
        logic [7:0] letter;
        logic       last;
    } latin_word_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    latin_word_t latin_due[$];      // words still owed by the block, oldest first
    latin_word_t head_word;
    glt_nasal_t  nasal_seen;        // shadow of the block's mu/nu memory
    int          n_mismatch;
    int          hold_cycles;       // long result-side hold-off requested by a test
    bit          rx_stall_en;
    bit          tx_idle_en;

    greek_latin_transliterator_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // work out the latin words for one accepted code byte and queue them
    task automatic transliterate_code(input logic [7:0] code);
        logic [23:0] seq;
        int          n;
        latin_word_t w;
        seq = {code, 16'h0000};
        n   = 1;
        if ((nasal_seen == NAS_MU_LO || nasal_seen == NAS_MU_UP) &&
            (code == CODE_PI_UP || code == CODE_PI_LO)) begin
            // mu before pi gives b, cased after the mu
            seq[23:16] = (nasal_seen == NAS_MU_LO) ? "b" : "B";
            nasal_seen = NAS_NONE;
        end else if ((nasal_seen == NAS_NU_LO || nasal_seen == NAS_NU_UP) &&
                     (code == CODE_TAU_UP || code == CODE_TAU_LO)) begin
            // nu before tau gives d, cased after the nu
            seq[23:16] = (nasal_seen == NAS_NU_LO) ? "d" : "D";
            nasal_seen = NAS_NONE;
        end else begin
            case (code)
                8'd0:   n = 0;
                8'd220: begin seq = {"a", ACUTE_MARK, 8'h00}; n = 2; end
                8'd221: begin seq = {"e", ACUTE_MARK, 8'h00}; n = 2; end
                8'd222: begin seq = {"h", ACUTE_MARK, 8'h00}; n = 2; end
                8'd223: begin seq = {"i", ACUTE_MARK, 8'h00}; n = 2; end
                8'd252: begin seq = {"o", ACUTE_MARK, 8'h00}; n = 2; end
                8'd253: begin seq = {"y", ACUTE_MARK, 8'h00}; n = 2; end
                8'd254: begin seq = {"w", ACUTE_MARK, 8'h00}; n = 2; end
                8'd182: begin seq = {ACUTE_MARK, "A", 8'h00}; n = 2; end
                8'd184: begin seq = {ACUTE_MARK, "E", 8'h00}; n = 2; end
                8'd185: begin seq = {ACUTE_MARK, "H", 8'h00}; n = 2; end
                8'd186: begin seq = {ACUTE_MARK, "I", 8'h00}; n = 2; end
                8'd188: begin seq = {ACUTE_MARK, "O", 8'h00}; n = 2; end
                8'd190: begin seq = {ACUTE_MARK, "Y", 8'h00}; n = 2; end
                8'd191: begin seq = {ACUTE_MARK, "W", 8'h00}; n = 2; end
                8'd218: begin seq = {"I", DIAER_MARK, 8'h00}; n = 2; end
                8'd219: begin seq = {"Y", DIAER_MARK, 8'h00}; n = 2; end
                8'd250: begin seq = {"i", DIAER_MARK, 8'h00}; n = 2; end
                8'd251: begin seq = {"u", DIAER_MARK, 8'h00}; n = 2; end
                8'd192: begin seq = {"i", ACUTE_MARK, DIAER_MARK}; n = 3; end
                8'd224: begin seq = {"u", ACUTE_MARK, DIAER_MARK}; n = 3; end
                8'd238: begin seq = {"ks", 8'h00}; n = 2; end
                8'd248: begin seq = {"ps", 8'h00}; n = 2; end
                8'd206: begin seq = {"KS", 8'h00}; n = 2; end
                8'd216: begin seq = {"PS", 8'h00}; n = 2; end
                default: begin
                    if (code >= 8'd225 && code <= 8'd249)
                        seq[23:16] = LATIN_LO[(249 - int'(code))*8 +: 8];
                    else if (code >= 8'd193 && code <= 8'd217)
                        seq[23:16] = LATIN_UP[(217 - int'(code))*8 +: 8];
                end
            endcase
            // only a plain mu or nu is remembered, anything else clears it
            case (code)
                CODE_MU_LO: nasal_seen = NAS_MU_LO;
                CODE_MU_UP: nasal_seen = NAS_MU_UP;
                CODE_NU_LO: nasal_seen = NAS_NU_LO;
                CODE_NU_UP: nasal_seen = NAS_NU_UP;
                default:    nasal_seen = NAS_NONE;
            endcase
        end
        for (int k = 0; k < n; k++) begin
            w.letter = seq[23-8*k -: 8];
            w.last   = (k == n - 1);
            latin_due.push_back(w);
        end
    endtask

    // offer one code byte, maybe after a random gap, and hold it until taken
    task automatic send_code(input logic [7:0] code);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do @(posedge aclk); while (!s_tready);
        transliterate_code(code);
    endtask

    // stop offering and wait for every owed word
    task automatic drain_words();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (latin_due.size() != 0);
    endtask

    // mostly greek codes, with extra weight on the nasal letters and pi/tau
    function automatic logic [7:0] pick_code();
        logic [7:0] nasal_pool [4];
        logic [7:0] stop_pool [4];
        int         roll;
        nasal_pool = '{CODE_MU_LO, CODE_MU_UP, CODE_NU_LO, CODE_NU_UP};
        stop_pool  = '{CODE_PI_LO, CODE_PI_UP, CODE_TAU_LO, CODE_TAU_UP};
        roll = $urandom_range(0, 9);
        if (roll < 3)
            return 8'($urandom_range(0, 255));
        else if (roll < 8)
            return 8'($urandom_range(160, 255));
        else if (roll == 8)
            return nasal_pool[$urandom_range(0, 3)];
        else
            return stop_pool[$urandom_range(0, 3)];
    endfunction

    // table corners, both nasal rules in both cases, and what breaks them
    task automatic test_directed();
        logic [7:0] codes [$];
        codes = '{8'd0, 8'd255, 8'd128, 8'd192, 8'd224, 8'd238, 8'd206, 8'd182,
                  8'd218, 8'd251, 8'd210,
                  CODE_MU_LO, CODE_PI_LO, CODE_MU_UP, CODE_PI_LO,
                  CODE_NU_LO, CODE_TAU_UP, CODE_NU_UP, CODE_TAU_LO,
                  CODE_MU_LO, CODE_NU_UP, CODE_TAU_UP,
                  CODE_MU_UP, 8'd0, CODE_PI_UP};
        foreach (codes[i])
            send_code(codes[i]);
        drain_words();
    endtask

    // mu or nu followed by a matching stop most of the time, else a mismatch,
    // a zero byte or a random pick that may be another nasal
    task automatic test_nasal_runs(input int runs);
        logic [7:0] nasal;
        int         roll;
        for (int r = 0; r < runs; r++) begin
            case ($urandom_range(0, 3))
                0: nasal = CODE_MU_LO;
                1: nasal = CODE_MU_UP;
                2: nasal = CODE_NU_LO;
                default: nasal = CODE_NU_UP;
            endcase
            send_code(nasal);
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                if (nasal == CODE_MU_LO || nasal == CODE_MU_UP)
                    send_code($urandom_range(0, 1) ? CODE_PI_UP : CODE_PI_LO);
                else
                    send_code($urandom_range(0, 1) ? CODE_TAU_UP : CODE_TAU_LO);
            end else if (roll == 6) begin
                if (nasal == CODE_MU_LO || nasal == CODE_MU_UP)
                    send_code($urandom_range(0, 1) ? CODE_TAU_UP : CODE_TAU_LO);
                else
                    send_code($urandom_range(0, 1) ? CODE_PI_UP : CODE_PI_LO);
            end else if (roll == 7) begin
                send_code(8'd0);
            end else begin
                send_code(pick_code());
            end
        end
        drain_words();
    endtask

    // result side held off for a long stretch while input keeps coming, so the
    // block fills up and stalls s_tready; then the sender waits for all words
    task automatic test_backpressure();
        bit idle_save;
        idle_save   = tx_idle_en;
        tx_idle_en  = 1'b0;
        hold_cycles = 80;
        for (int i = 0; i < 20; i++)
            send_code(pick_code());
        tx_idle_en = idle_save;
        drain_words();
    endtask

    task automatic test_random_text(input int count);
        for (int i = 0; i < count; i++)
            send_code(pick_code());
        drain_words();
    endtask

    task automatic note_mismatch(input string what, input logic [7:0] exp_letter,
                                 input logic exp_last);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("%0t: %s: expected data %0d last %0b, got data %0d last %0b",
                     $realtime, what, exp_letter, exp_last, m_tdata, m_tlast);
    endtask

    // compare every word taken off the result stream with the oldest owed word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (latin_due.size() == 0) begin
                note_mismatch("unexpected word", 8'h00, 1'b0);
            end else begin
                head_word = latin_due.pop_front();
                if (m_tdata !== head_word.letter || m_tlast !== head_word.last)
                    note_mismatch("wrong word", head_word.letter, head_word.last);
            end
        end
    end

    // result-side readiness: long hold-off on request, else random stalls
    initial begin
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else if (rx_stall_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        n_mismatch  = 0;
        hold_cycles = 0;
        rx_stall_en = 1'b1;
        tx_idle_en  = 1'b1;
        nasal_seen  = NAS_NONE;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_nasal_runs(28);
        test_backpressure();
        test_random_text(29);
        // closing stretch with both sides always ready
        rx_stall_en = 1'b0;
        tx_idle_en  = 1'b0;
        test_nasal_runs(10);
        test_random_text(20);

        // a zero byte owes nothing, so give the block time to settle
        repeat (20) @(posedge aclk);
        if (n_mismatch == 0 && latin_due.size() == 0)
            $display("** greek_latin_transliterator_core: PASSED **");
        else
            $display("** greek_latin_transliterator_core: FAILED **");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** greek_latin_transliterator_core: FAILED **");
        $finish;
    end

endmodule
